// ===== design/sbe_pkg.sv =====
// Shared types and constants for the stack bytecode executor.
// Used by every module of the block but sbe_ram; depends on nothing else.
package sbe_pkg;

  // Field widths of the item channels
  localparam int unsigned OP_W       = 5;
  localparam int unsigned OPND_W     = 32;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned STAT_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned LOCN_W     = 9;
  localparam int unsigned CONSTN_W   = 11;
  localparam int unsigned STEP_W     = 20;

  // Parameter defaults
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned LOCALS_MAX_DEF  = 256;
  localparam int unsigned CONSTS_MAX_DEF  = 1024;
  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 20'd100000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCALS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 5'd0,
    OP_WRCONST = 5'd1,
    OP_PUSH   = 5'd2,
    OP_LOAD   = 5'd3,
    OP_STORE  = 5'd4,
    OP_ADD    = 5'd5,
    OP_SUB    = 5'd6,
    OP_MUL    = 5'd7,
    OP_DIV    = 5'd8,
    OP_MOD    = 5'd9,
    OP_NEG    = 5'd10,
    OP_POP    = 5'd11,
    OP_EQ     = 5'd12,
    OP_NE     = 5'd13,
    OP_LT     = 5'd14,
    OP_LE     = 5'd15,
    OP_GT     = 5'd16,
    OP_GE     = 5'd17,
    OP_AND    = 5'd18,
    OP_OR     = 5'd19,
    OP_NOT    = 5'd20,
    OP_JMP    = 5'd21,
    OP_JF     = 5'd22,
    OP_JT     = 5'd23,
    OP_RET    = 5'd24,
    OP_CALL   = 5'd25,
    OP_OTHER  = 5'd26
  } sbe_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_RUN      = 4'd0,
    ST_RET      = 4'd1,
    ST_UNDER    = 4'd2,
    ST_BADLOC   = 4'd3,
    ST_BADCONST = 4'd4,
    ST_DIVZERO  = 4'd5,
    ST_UNSUP    = 4'd6,
    ST_LIMIT    = 4'd7,
    ST_OVER     = 4'd8
  } sbe_status_e;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_MOD
  } sbe_md_e;

  typedef enum logic [2:0] {
    S_CLR_RST,
    S_IDLE,
    S_ISSUE,
    S_EXEC,
    S_MULDIV,
    S_CLR_START,
    S_DONE
  } sbe_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic issue;
    logic md_start;
    logic commit;
    logic clear;
    logic out_load;
  } sbe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic need_exec;
    logic is_muldiv;
    logic md_done;
    logic clr_last;
  } sbe_stat_t;

endpackage

// ===== design/sbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Uses no package; instanced for the stack, locals and constant pool.
module sbe_ram #(
  parameter int unsigned W = 64,
  parameter int unsigned D = 64
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                        wdata_i,
  input  logic                                re_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                        rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sbe_muldiv.sv =====
// Bit-serial 64-bit multiply and signed divide/modulo, one bit per cycle.
// Depends on sbe_pkg for the operation kind.
module sbe_muldiv import sbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sbe_md_e           mode_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic              done_o,
  output logic [DATA_W-1:0] result_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [5:0]        cnt_q, cnt_d;
  sbe_md_e           mode_q, mode_d;
  logic [DATA_W-1:0] acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic              nega_q, nega_d, negq_q, negq_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  // restoring divide step: remainder shifted with next dividend bit
  assign trial = {acc_q, x_q[DATA_W-1]};
  assign diff  = trial - {1'b0, y_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    nega_d = nega_q;
    negq_d = negq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mode_d = mode_i;
      acc_d  = '0;
      nega_d = a_i[DATA_W-1];
      negq_d = a_i[DATA_W-1] ^ b_i[DATA_W-1];
      if (mode_i == MD_MUL) begin
        x_d = a_i;
        y_d = b_i;
      end else begin
        x_d = a_i[DATA_W-1] ? (~a_i + 64'd1) : a_i;
        y_d = b_i[DATA_W-1] ? (~b_i + 64'd1) : b_i;
      end
    end else if (busy_q) begin
      if (mode_q == MD_MUL) begin
        if (y_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d = {x_q[DATA_W-2:0], 1'b0};
        y_d = {1'b0, y_q[DATA_W-1:1]};
      end else begin
        if (!diff[DATA_W]) begin
          acc_d = diff[DATA_W-1:0];
        end else begin
          acc_d = trial[DATA_W-1:0];
        end
        x_d = {x_q[DATA_W-2:0], ~diff[DATA_W]};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= MD_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    nega_q <= nega_d;
    negq_q <= negq_d;
  end

  // sign fix-up of quotient and remainder
  always_comb begin
    unique case (mode_q)
      MD_MUL:  result_o = acc_q;
      MD_DIV:  result_o = negq_q ? (~x_q + 64'd1) : x_q;
      default: result_o = nega_q ? (~acc_q + 64'd1) : acc_q;
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== design/sbe_ctrl.sv =====
// Sequencing state machine of the executor: handshakes and step commands.
// Depends on sbe_pkg for the state, command and status types.
module sbe_ctrl import sbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sbe_stat_t stat_i,
  output sbe_cmd_t  cmd_o
);

  sbe_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR_RST: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_ISSUE;
      end
      S_ISSUE: begin
        if (stat_i.is_start) state_d = S_CLR_START;
        else if (stat_i.need_exec) state_d = S_EXEC;
        else state_d = S_DONE;
      end
      S_EXEC: begin
        if (stat_i.is_muldiv) state_d = S_MULDIV;
        else state_d = S_DONE;
      end
      S_MULDIV: begin
        if (stat_i.md_done) state_d = S_DONE;
      end
      S_CLR_START: begin
        if (stat_i.clr_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.issue    = (state_q == S_ISSUE);
    cmd_o.md_start = (state_q == S_EXEC) && stat_i.is_muldiv;
    cmd_o.commit   = ((state_q == S_EXEC) && !stat_i.is_muldiv) ||
                     ((state_q == S_MULDIV) && stat_i.md_done);
    cmd_o.clear    = (state_q == S_CLR_RST) || (state_q == S_CLR_START);
    cmd_o.out_load = (state_q == S_DONE) && out_free;
  end

  // result beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/sbe_dp.sv =====
// Datapath of the executor: stack, locals and pool memories, ALU, status.
// Depends on sbe_pkg, sbe_ram and sbe_muldiv.
module sbe_dp import sbe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned LOCALS_MAX  = LOCALS_MAX_DEF,
  parameter int unsigned CONSTS_MAX  = CONSTS_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbe_cmd_t                          cmd_i,
  output sbe_stat_t                         stat_o,
  input  logic [OP_W-1:0]                   operation_i,
  input  logic [OPND_W-1:0]                 operand_i,
  input  logic signed [DATA_W-1:0]          data_value_i,
  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [CFG_DATA_W-1:0]             cfg_data_i,
  output logic [STAT_W-1:0]                 status_o,
  output logic signed [DATA_W-1:0]          top_value_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]  stack_depth_o,
  output logic                              branch_taken_o,
  output logic [OPND_W-1:0]                 branch_target_o
);

  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SaW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LaW = (LOCALS_MAX > 1) ? $clog2(LOCALS_MAX) : 1;
  localparam int unsigned CaW = (CONSTS_MAX > 1) ? $clog2(CONSTS_MAX) : 1;

  // latched item
  logic [OP_W-1:0]   op_q;
  logic [OPND_W-1:0] opnd_q;
  logic [DATA_W-1:0] data_q;

  // architectural state
  logic [SpW-1:0]    sp_q, sp_d;
  logic [DATA_W-1:0] tos_q, tos_d;
  logic [STEP_W-1:0] step_q, step_d;
  sbe_status_e       status_q, status_d;
  logic              taken_q, taken_d;
  logic [OPND_W-1:0] target_q, target_d;
  logic [LaW-1:0]    clr_q, clr_d;
  logic [LOCN_W-1:0]   locals_in_use_q;
  logic [CONSTN_W-1:0] consts_in_use_q;
  logic [STEP_W-1:0]   step_limit_q;

  // output registers
  logic [STAT_W-1:0] out_status_q;
  logic [DATA_W-1:0] out_top_q;
  logic [SpW-1:0]    out_depth_q;
  logic              out_taken_q;
  logic [OPND_W-1:0] out_target_q;

  logic [OPND_W-1:0] lim_l, lim_c;
  logic              bad_l, bad_c, run, limit_hit, exec_ok, clr_last;
  logic              sp_zero, sp_lt2, sp_full, tos_zero;
  logic [SpW-1:0]    sp_m1, sp_m2;
  sbe_status_e       chk;
  logic              is_exec_op, is_muldiv;

  // memory ports
  logic              stk_we;
  logic [SaW-1:0]    stk_waddr, stk_raddr;
  logic [DATA_W-1:0] stk_wdata, stk_rdata;
  logic              loc_we;
  logic [LaW-1:0]    loc_waddr;
  logic [DATA_W-1:0] loc_wdata, loc_rdata;
  logic              pool_we;
  logic [DATA_W-1:0] pool_rdata;

  logic [DATA_W-1:0] alu_r, bin_r, push_v, md_res;
  logic              md_done;
  sbe_md_e           md_mode;

  // item latch and configuration
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      opnd_q <= operand_i;
      data_q <= data_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locals_in_use_q <= '0;
      consts_in_use_q <= '0;
      step_limit_q    <= STEP_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOCALS: locals_in_use_q <= cfg_data_i[LOCN_W-1:0];
        CFG_CONSTS: consts_in_use_q <= cfg_data_i[CONSTN_W-1:0];
        CFG_LIMIT:  step_limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // index limits and stack checks
  assign lim_l = ({23'b0, locals_in_use_q} < OPND_W'(LOCALS_MAX)) ?
                 {23'b0, locals_in_use_q} : OPND_W'(LOCALS_MAX);
  assign lim_c = ({21'b0, consts_in_use_q} < OPND_W'(CONSTS_MAX)) ?
                 {21'b0, consts_in_use_q} : OPND_W'(CONSTS_MAX);
  assign bad_l = opnd_q >= lim_l;
  assign bad_c = opnd_q >= lim_c;
  assign run       = (status_q == ST_RUN);
  assign limit_hit = (step_q >= step_limit_q);
  assign sp_zero   = (sp_q == '0);
  assign sp_lt2    = (sp_q < SpW'(2));
  assign sp_full   = (sp_q >= SpW'(STACK_DEPTH));
  assign sp_m1     = sp_q - SpW'(1);
  assign sp_m2     = sp_q - SpW'(2);
  assign tos_zero  = (tos_q == '0);
  assign clr_last  = (clr_q == LaW'(LOCALS_MAX - 1));

  // failure check of the latched instruction
  always_comb begin
    chk = ST_RUN;
    unique case (op_q) inside
      OP_PUSH: begin
        if (bad_c) chk = ST_BADCONST;
        else if (sp_full) chk = ST_OVER;
      end
      OP_LOAD: begin
        if (bad_l) chk = ST_BADLOC;
        else if (sp_full) chk = ST_OVER;
      end
      OP_STORE: begin
        if (sp_zero) chk = ST_UNDER;
        else if (bad_l) chk = ST_BADLOC;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
      OP_AND, OP_OR: begin
        if (sp_lt2) chk = ST_UNDER;
      end
      OP_DIV, OP_MOD: begin
        if (sp_lt2) chk = ST_UNDER;
        else if (tos_zero) chk = ST_DIVZERO;
      end
      OP_NEG, OP_POP, OP_NOT, OP_JF, OP_JT: begin
        if (sp_zero) chk = ST_UNDER;
      end
      OP_JMP, OP_START, OP_WRCONST: chk = ST_RUN;
      OP_RET:  chk = ST_RET;
      default: chk = ST_UNSUP;
    endcase
  end

  always_comb begin
    unique case (op_q) inside
      OP_PUSH, OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POP,
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE, OP_AND, OP_OR,
      OP_JF, OP_JT: is_exec_op = 1'b1;
      default:      is_exec_op = 1'b0;
    endcase
  end

  assign is_muldiv = (op_q == OP_MUL) || (op_q == OP_DIV) || (op_q == OP_MOD);
  assign exec_ok   = (op_q != OP_START) && (op_q != OP_WRCONST) && run &&
                     !limit_hit && (chk == ST_RUN);

  assign stat_o.is_start  = (op_q == OP_START);
  assign stat_o.need_exec = exec_ok && is_exec_op;
  assign stat_o.is_muldiv = is_muldiv;
  assign stat_o.md_done   = md_done;
  assign stat_o.clr_last  = clr_last;

  // two-operand ALU, a under b
  always_comb begin
    unique case (op_q)
      OP_ADD:  alu_r = stk_rdata + tos_q;
      OP_SUB:  alu_r = stk_rdata - tos_q;
      OP_EQ:   alu_r = {63'b0, stk_rdata == tos_q};
      OP_NE:   alu_r = {63'b0, stk_rdata != tos_q};
      OP_LT:   alu_r = {63'b0, $signed(stk_rdata) < $signed(tos_q)};
      OP_LE:   alu_r = {63'b0, $signed(stk_rdata) <= $signed(tos_q)};
      OP_GT:   alu_r = {63'b0, $signed(stk_rdata) > $signed(tos_q)};
      OP_GE:   alu_r = {63'b0, $signed(stk_rdata) >= $signed(tos_q)};
      OP_AND:  alu_r = {63'b0, (stk_rdata != '0) && !tos_zero};
      default: alu_r = {63'b0, (stk_rdata != '0) || !tos_zero};
    endcase
  end

  assign bin_r  = is_muldiv ? md_res : alu_r;
  assign push_v = (op_q == OP_PUSH) ? pool_rdata : loc_rdata;

  always_comb begin
    unique case (op_q)
      OP_MUL:  md_mode = MD_MUL;
      OP_DIV:  md_mode = MD_DIV;
      default: md_mode = MD_MOD;
    endcase
  end

  sbe_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .mode_i   (md_mode),
    .a_i      (stk_rdata),
    .b_i      (tos_q),
    .done_o   (md_done),
    .result_o (md_res)
  );

  // stack memory port control
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp_q[SaW-1:0];
    stk_wdata = push_v;
    if (cmd_i.issue && exec_ok && (op_q == OP_NEG)) begin
      stk_we    = 1'b1;
      stk_waddr = sp_m1[SaW-1:0];
      stk_wdata = ~tos_q + 64'd1;
    end else if (cmd_i.issue && exec_ok && (op_q == OP_NOT)) begin
      stk_we    = 1'b1;
      stk_waddr = sp_m1[SaW-1:0];
      stk_wdata = {63'b0, tos_zero};
    end else if (cmd_i.commit && ((op_q == OP_PUSH) || (op_q == OP_LOAD))) begin
      stk_we = 1'b1;
    end else if (cmd_i.commit && (op_q != OP_POP) && (op_q != OP_JF) &&
                 (op_q != OP_JT)) begin
      stk_we    = 1'b1;
      stk_waddr = sp_m2[SaW-1:0];
      stk_wdata = bin_r;
    end
  end

  assign stk_raddr = sp_lt2 ? '0 : sp_m2[SaW-1:0];

  // locals: clearing sweep or store
  assign loc_we    = cmd_i.clear || (cmd_i.issue && exec_ok && (op_q == OP_STORE));
  assign loc_waddr = cmd_i.clear ? clr_q : opnd_q[LaW-1:0];
  assign loc_wdata = cmd_i.clear ? '0 : tos_q;

  assign pool_we = cmd_i.issue && (op_q == OP_WRCONST) &&
                   (opnd_q < OPND_W'(CONSTS_MAX));

  sbe_ram #(.W(DATA_W), .D(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  sbe_ram #(.W(DATA_W), .D(LOCALS_MAX)) u_locals_ram (
    .clk_i   (clk_i),
    .we_i    (loc_we),
    .waddr_i (loc_waddr),
    .wdata_i (loc_wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (opnd_q[LaW-1:0]),
    .rdata_o (loc_rdata)
  );

  sbe_ram #(.W(DATA_W), .D(CONSTS_MAX)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (opnd_q[CaW-1:0]),
    .wdata_i (data_q),
    .re_i    (cmd_i.issue),
    .raddr_i (opnd_q[CaW-1:0]),
    .rdata_o (pool_rdata)
  );

  // state update
  always_comb begin
    sp_d     = sp_q;
    tos_d    = tos_q;
    step_d   = step_q;
    status_d = status_q;
    taken_d  = taken_q;
    target_d = target_q;
    clr_d    = clr_q;
    if (cmd_i.issue) begin
      taken_d  = 1'b0;
      target_d = '0;
      if (op_q == OP_START) begin
        sp_d     = '0;
        step_d   = '0;
        status_d = ST_RUN;
        clr_d    = '0;
      end else if ((op_q != OP_WRCONST) && run) begin
        if (limit_hit) begin
          status_d = ST_LIMIT;
        end else begin
          step_d = step_q + STEP_W'(1);
          if (chk != ST_RUN) begin
            status_d = chk;
          end else begin
            unique case (op_q)
              OP_NEG: tos_d = ~tos_q + 64'd1;
              OP_NOT: tos_d = {63'b0, tos_zero};
              OP_JMP: begin
                taken_d  = 1'b1;
                target_d = opnd_q;
              end
              OP_JF: begin
                taken_d  = tos_zero;
                target_d = tos_zero ? opnd_q : '0;
              end
              OP_JT: begin
                taken_d  = !tos_zero;
                target_d = tos_zero ? '0 : opnd_q;
              end
              default: ;
            endcase
          end
        end
      end
    end
    if (cmd_i.clear) begin
      clr_d = clr_last ? '0 : clr_q + LaW'(1);
    end
    if (cmd_i.commit) begin
      unique case (op_q) inside
        OP_PUSH, OP_LOAD: begin
          tos_d = push_v;
          sp_d  = sp_q + SpW'(1);
        end
        OP_POP, OP_JF, OP_JT: begin
          tos_d = stk_rdata;
          sp_d  = sp_m1;
        end
        default: begin
          tos_d = bin_r;
          sp_d  = sp_m1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      step_q   <= '0;
      status_q <= ST_RUN;
      taken_q  <= 1'b0;
      target_q <= '0;
      clr_q    <= '0;
    end else begin
      sp_q     <= sp_d;
      step_q   <= step_d;
      status_q <= status_d;
      taken_q  <= taken_d;
      target_q <= target_d;
      clr_q    <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_top_q    <= sp_zero ? '0 : tos_q;
      out_depth_q  <= sp_q;
      out_taken_q  <= taken_q;
      out_target_q <= target_q;
    end
  end

  assign status_o        = out_status_q;
  assign top_value_o     = out_top_q;
  assign stack_depth_o   = out_depth_q;
  assign branch_taken_o  = out_taken_q;
  assign branch_target_o = out_target_q;

endmodule

// ===== design/stack_bytecode_executor.sv =====
// Top level of the stack bytecode executor: controller plus datapath.
// Depends on sbe_pkg, sbe_ctrl and sbe_dp.
//
//  channel  direction  handshake                fields
//  in       input      in_valid_i / in_stall_o   operation, operand, data_value
//  out      output     out_valid_o / out_stall_i status, top_value, stack_depth,
//                                                branch_taken, branch_target
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item at a time. Push, load, pop, jf, jt and two-operand ops go from
// issue through an execute state to done (registered memory read); jmp,
// store, neg, not, ret and failed or latched items go from issue to done;
// mul/div/mod wait on the bit-serial unit (64 steps); start sweeps the locals.
// After reset the locals are swept to zero before the first item is taken;
// cfg writes are taken at any time.
// The next item is accepted while a result beat still waits on out_stall_i.
module stack_bytecode_executor import sbe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned LOCALS_MAX  = LOCALS_MAX_DEF,
  parameter int unsigned CONSTS_MAX  = CONSTS_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [OP_W-1:0]                  operation_i,
  input  logic [OPND_W-1:0]                operand_i,
  input  logic signed [DATA_W-1:0]         data_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [STAT_W-1:0]                status_o,
  output logic signed [DATA_W-1:0]         top_value_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0] stack_depth_o,
  output logic                             branch_taken_o,
  output logic [OPND_W-1:0]                branch_target_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [CFG_DATA_W-1:0]            cfg_data_i
);

  sbe_cmd_t  cmd;
  sbe_stat_t stat;

  assign cfg_ready_o = 1'b1;

  sbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sbe_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .LOCALS_MAX  (LOCALS_MAX),
    .CONSTS_MAX  (CONSTS_MAX)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .operand_i       (operand_i),
    .data_value_i    (data_value_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (status_o),
    .top_value_o     (top_value_o),
    .stack_depth_o   (stack_depth_o),
    .branch_taken_o  (branch_taken_o),
    .branch_target_o (branch_target_o)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stack_bytecode_executor: directed and random instruction streams.
// Depends on sbe_pkg and the RTL of the block; results are checked against an in-bench predictor.
module tb_top;
  import sbe_pkg::*;

  localparam int unsigned NSTK  = STACK_DEPTH_DEF;
  localparam int unsigned NLOC  = LOCALS_MAX_DEF;
  localparam int unsigned NCON  = CONSTS_MAX_DEF;
  localparam logic [63:0] MINV  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXV  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OP_W-1:0]         operation_i;
  logic [OPND_W-1:0]       operand_i;
  logic signed [DATA_W-1:0] data_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [STAT_W-1:0]       status_o;
  logic signed [DATA_W-1:0] top_value_o;
  logic [6:0]              stack_depth_o;
  logic                    branch_taken_o;
  logic [OPND_W-1:0]       branch_target_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  stack_bytecode_executor u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .operand_i, .data_value_i,
    .out_valid_o, .out_stall_i, .status_o, .top_value_o, .stack_depth_o,
    .branch_taken_o, .branch_target_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [63:0]       top;
    logic [6:0]        depth;
    logic              taken;
    logic [31:0]       target;
  } step_result_t;

  step_result_t exp_results[$];
  int           n_errors;
  bit           gaps_on;
  bit           stalls_on;

  // Shadow machine state
  logic [63:0]       sh_stack [NSTK];
  int unsigned       sh_sp;
  logic [63:0]       sh_locals [NLOC];
  logic [63:0]       sh_pool [NCON];
  bit                pool_set [NCON];
  logic [19:0]       sh_steps;
  sbe_status_e       sh_status;
  logic [8:0]        reg_locals;
  logic [10:0]       reg_consts;
  logic [19:0]       reg_limit;

  function automatic int unsigned locals_lim();
    return (reg_locals < NLOC) ? reg_locals : NLOC;
  endfunction

  function automatic int unsigned consts_lim();
    return (reg_consts < NCON) ? reg_consts : NCON;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Signed divide / remainder, truncating toward zero
  function automatic logic [63:0] trunc_div(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    q = mag(a) / mag(b);
    return (a[63] != b[63]) ? (64'd0 - q) : q;
  endfunction

  function automatic logic [63:0] trunc_rem(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = mag(a) % mag(b);
    return a[63] ? (64'd0 - r) : r;
  endfunction

  // Executes one instruction on the shadow state
  task automatic run_instr(input logic [4:0] op, input logic [31:0] opnd,
                           output logic taken, output logic [31:0] target);
    logic [63:0] a, b, r, v;
    taken = 1'b0;
    target = '0;
    r = '0;
    case (op)
      OP_PUSH, OP_LOAD: begin
        if (op == OP_PUSH) begin
          if (opnd >= consts_lim()) begin sh_status = ST_BADCONST; return; end
          v = sh_pool[opnd];
        end else begin
          if (opnd >= locals_lim()) begin sh_status = ST_BADLOC; return; end
          v = sh_locals[opnd];
        end
        if (sh_sp >= NSTK) begin sh_status = ST_OVER; return; end
        sh_stack[sh_sp] = v;
        sh_sp++;
      end
      OP_STORE: begin
        if (sh_sp == 0) begin sh_status = ST_UNDER; return; end
        if (opnd >= locals_lim()) begin sh_status = ST_BADLOC; return; end
        sh_locals[opnd] = sh_stack[sh_sp-1];
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
      OP_AND, OP_OR: begin
        if (sh_sp < 2) begin sh_status = ST_UNDER; return; end
        a = sh_stack[sh_sp-2];
        b = sh_stack[sh_sp-1];
        if ((op == OP_DIV || op == OP_MOD) && b == 0) begin sh_status = ST_DIVZERO; return; end
        case (op)
          OP_ADD: r = a + b;
          OP_SUB: r = a - b;
          OP_MUL: r = a * b;
          OP_DIV: r = trunc_div(a, b);
          OP_MOD: r = trunc_rem(a, b);
          OP_EQ:  r = 64'(a == b);
          OP_NE:  r = 64'(a != b);
          OP_LT:  r = 64'($signed(a) < $signed(b));
          OP_LE:  r = 64'($signed(a) <= $signed(b));
          OP_GT:  r = 64'($signed(a) > $signed(b));
          OP_GE:  r = 64'($signed(a) >= $signed(b));
          OP_AND: r = 64'(a != 0 && b != 0);
          default: r = 64'(a != 0 || b != 0);
        endcase
        sh_sp -= 2;
        sh_stack[sh_sp] = r;
        sh_sp++;
      end
      OP_NEG, OP_POP, OP_NOT: begin
        if (sh_sp == 0) begin sh_status = ST_UNDER; return; end
        a = sh_stack[sh_sp-1];
        if (op == OP_NEG) sh_stack[sh_sp-1] = 64'd0 - a;
        else if (op == OP_NOT) sh_stack[sh_sp-1] = 64'(a == 0);
        else sh_sp--;
      end
      OP_JMP: begin
        taken = 1'b1;
        target = opnd;
      end
      OP_JF, OP_JT: begin
        if (sh_sp == 0) begin sh_status = ST_UNDER; return; end
        sh_sp--;
        a = sh_stack[sh_sp];
        if ((op == OP_JF) == (a == 0)) begin
          taken = 1'b1;
          target = opnd;
        end
      end
      OP_RET: sh_status = ST_RET;
      default: sh_status = ST_UNSUP;
    endcase
  endtask

  // Predicts the result beat of one accepted item
  task automatic predict_step(input logic [4:0] op, input logic [31:0] opnd,
                              input logic [63:0] data);
    step_result_t res;
    logic         taken;
    logic [31:0]  target;
    taken = 1'b0;
    target = '0;
    if (op == OP_START) begin
      sh_sp = 0;
      foreach (sh_locals[i]) sh_locals[i] = '0;
      sh_steps = '0;
      sh_status = ST_RUN;
    end else if (op == OP_WRCONST) begin
      if (opnd < NCON) begin
        sh_pool[opnd] = data;
        pool_set[opnd] = 1'b1;
      end
    end else if (sh_status == ST_RUN) begin
      if (sh_steps >= reg_limit) begin
        sh_status = ST_LIMIT;
      end else begin
        sh_steps = sh_steps + 20'd1;
        run_instr(op, opnd, taken, target);
      end
    end
    res.status = sh_status;
    res.top    = (sh_sp != 0) ? sh_stack[sh_sp-1] : '0;
    res.depth  = 7'(sh_sp);
    res.taken  = taken;
    res.target = target;
    exp_results.insert(exp_results.size(), res);
  endtask

  // Sends one instruction beat and records its expected result
  task automatic send_instr(input logic [4:0] op, input logic [31:0] opnd,
                            input logic [63:0] data = '0);
    int gap;
    gap = 0;
    if (gaps_on) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(5, 40);
      endcase
    end
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    operation_i  = op;
    operand_i    = opnd;
    data_value_i = data;
    do @(posedge clk_i); while (in_stall_o);
    predict_step(op, opnd, data);
    @(negedge clk_i);
  endtask

  // Config write, only between phases with nothing outstanding
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
    in_valid_i = 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LOCALS: reg_locals = val[8:0];
      CFG_CONSTS: reg_consts = val[10:0];
      CFG_LIMIT:  reg_limit  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_regs(input logic [19:0] nloc, input logic [19:0] ncon,
                          input logic [19:0] lim);
    write_reg(CFG_LOCALS, nloc);
    write_reg(CFG_CONSTS, ncon);
    write_reg(CFG_LIMIT, lim);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 64'd1;
      2: return ONES;
      3: return MINV;
      4: return MAXV;
      5: return 64'($signed($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Constant index that is either written or outside the pool limit
  function automatic logic [31:0] pick_const();
    logic [31:0] idx;
    if (consts_lim() > 0 && $urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, consts_lim() - 1);
      if (!pool_set[idx]) idx = $urandom_range(0, 31);
      if (idx < consts_lim() && pool_set[idx]) return idx;
    end
    idx = $urandom_range(0, 1) ? consts_lim() + $urandom_range(0, 3) : $urandom;
    if (idx < consts_lim() && !pool_set[idx]) idx = consts_lim();
    return idx;
  endfunction

  function automatic logic [31:0] pick_local();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, locals_lim());
  endfunction

  // Random instruction, weighted toward well-formed stack programs
  task automatic rand_instr();
    int          w;
    logic [4:0]  op;
    logic [31:0] opnd;
    w = $urandom_range(0, 99);
    opnd = $urandom;
    if (sh_status != ST_RUN && $urandom_range(0, 3) != 0) begin
      op = OP_START;
    end else if (sh_sp < 2 && w < 60) begin
      op = w < 40 ? OP_PUSH : OP_LOAD;
    end else if (w < 15) begin
      op = OP_PUSH;
    end else if (w < 24) begin
      op = OP_LOAD;
    end else if (w < 31) begin
      op = OP_STORE;
    end else if (w < 51) begin
      op = 5'($urandom_range(OP_ADD, OP_MOD));
    end else if (w < 58) begin
      op = $urandom_range(0, 1) ? OP_NEG : OP_POP;
    end else if (w < 73) begin
      op = 5'($urandom_range(OP_EQ, OP_NOT));
    end else if (w < 85) begin
      op = 5'($urandom_range(OP_JMP, OP_JT));
    end else if (w < 87) begin
      op = OP_RET;
    end else if (w < 89) begin
      op = $urandom_range(0, 1) ? 5'($urandom_range(OP_CALL, 31)) : OP_OTHER;
    end else if (w < 96) begin
      op = OP_WRCONST;
      if ($urandom_range(0, 3) != 0) opnd = $urandom_range(0, NCON - 1);
    end else begin
      op = OP_START;
    end
    if (op == OP_PUSH) opnd = pick_const();
    if (op == OP_LOAD || op == OP_STORE) opnd = pick_local();
    send_instr(op, opnd, rand_word());
  endtask

  // Result checker
  always @(posedge clk_i) begin
    step_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat: status %0d", status_o);
      end else begin
        e = exp_results.pop_front();
        if (status_o !== e.status || top_value_o !== e.top || stack_depth_o !== e.depth ||
            branch_taken_o !== e.taken || branch_target_o !== e.target) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp st %0d top %h dep %0d tk %b tgt %h / got %0d %h %0d %b %h",
                     e.status, e.top, e.depth, e.taken, e.target, status_o, top_value_o,
                     stack_depth_o, branch_taken_o, branch_target_o);
        end
      end
    end
  end

  // Receiver back-pressure
  int stall_left;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!stalls_on) begin
      out_stall_i <= 1'b0;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
    end
  end

  // Arithmetic corners, branches and ignored constant writes
  task automatic test_ops();
    set_regs(20'd4, 20'd8, 20'd100000);
    send_instr(OP_WRCONST, 32'd0, MINV);
    send_instr(OP_WRCONST, 32'd1, ONES);
    send_instr(OP_WRCONST, 32'd2, MAXV);
    send_instr(OP_WRCONST, 32'd3, 64'd0);
    send_instr(OP_WRCONST, 32'd4, 64'd7);
    send_instr(OP_WRCONST, 32'd5, 64'hFFFF_FFFF_FFFF_FFFD);
    send_instr(OP_WRCONST, 32'hFFFF_FFFF, 64'h5A5A_5A5A_A5A5_A5A5);
    send_instr(OP_START, '0);
    send_instr(OP_PUSH, 32'd0);
    send_instr(OP_PUSH, 32'd1);
    send_instr(OP_DIV, '0);
    send_instr(OP_PUSH, 32'd1);
    send_instr(OP_MOD, '0);
    send_instr(OP_PUSH, 32'd4);
    send_instr(OP_PUSH, 32'd5);
    send_instr(OP_MOD, '0);
    send_instr(OP_PUSH, 32'd2);
    send_instr(OP_MUL, '0);
    send_instr(OP_STORE, 32'd3);
    send_instr(OP_LOAD, 32'd3);
    send_instr(OP_GE, '0);
    send_instr(OP_JT, 32'hFFFF_FFFF);
    send_instr(OP_JMP, 32'hA5A5_5A5A);
    send_instr(OP_JF, 32'd0);
    send_instr(OP_RET, '0);
  endtask

  // Underflow, bad constant, bad local and unsupported statuses, latched behavior and restart
  task automatic test_failures();
    set_regs(20'd2, 20'd6, 20'd100000);
    send_instr(OP_START, '0);
    send_instr(OP_ADD, '0);
    send_instr(OP_PUSH, 32'd0);
    send_instr(OP_START, '0);
    send_instr(OP_PUSH, 32'd6);
    send_instr(OP_START, '0);
    send_instr(OP_LOAD, 32'd2);
    send_instr(OP_START, '0);
    send_instr(OP_STORE, 32'd9);
    send_instr(OP_START, '0);
    send_instr(OP_PUSH, 32'd3);
    send_instr(OP_STORE, 32'd5);
    send_instr(OP_PUSH, 32'd3);
    send_instr(OP_DIV, '0);
    send_instr(OP_START, '0);
    send_instr(OP_CALL, '0);
    send_instr(OP_START, '0);
    send_instr(5'd31, '0);
    send_instr(OP_WRCONST, 32'd5, 64'd11);
    send_instr(OP_START, '0);
    send_instr(OP_RET, '0);
  endtask

  // Step limit, including a limit of zero, and stack overflow
  task automatic test_limits();
    set_regs(20'd1, 20'd6, 20'd3);
    send_instr(OP_START, '0);
    repeat (4) send_instr(OP_PUSH, 32'd4);
    write_reg(CFG_LIMIT, 20'd0);
    send_instr(OP_START, '0);
    send_instr(OP_POP, '0);
    set_regs(20'd1, 20'd1024, 20'hFFFFF);
    send_instr(OP_START, '0);
    repeat (NSTK + 1) send_instr(OP_LOAD, 32'd0);
  endtask

  task automatic test_random(input logic [19:0] nloc, input logic [19:0] ncon,
                             input logic [19:0] lim, input int count);
    set_regs(nloc, ncon, lim);
    for (int i = 0; i < 32; i++) send_instr(OP_WRCONST, 32'(i), rand_word());
    send_instr(OP_START, '0);
    repeat (count) rand_instr();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = '0;
    operand_i = '0;
    data_value_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    n_errors = 0;
    stall_left = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    sh_sp = 0;
    sh_steps = '0;
    sh_status = ST_RUN;
    reg_locals = '0;
    reg_consts = '0;
    reg_limit = STEP_LIMIT_RST;
    foreach (sh_stack[i]) sh_stack[i] = '0;
    foreach (sh_locals[i]) sh_locals[i] = '0;
    foreach (sh_pool[i]) begin
      sh_pool[i] = '0;
      pool_set[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_ops();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_failures();
    test_limits();
    test_random(20'd16, 20'd32, 20'hFFFFF, 500);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random(20'd256, 20'd1024, 20'd40, 250);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_random(20'd511, 20'd2047, 20'd100000, 350);
    test_random(20'd0, 20'd0, 20'd1, 60);
    test_random(20'd8, 20'd20, 20'd100000, 150);

    // Drain and let the pipeline settle
    in_valid_i = 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && exp_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
design/sbe_pkg.sv
design/sbe_ram.sv
design/sbe_muldiv.sv
design/sbe_ctrl.sv
design/sbe_dp.sv
design/stack_bytecode_executor.sv
dv/tb_top.sv
